>>> design/eikonal_fast_sweep_grid_macros.svh
// assertion macros for the sweep grid checker
`ifndef EIKONAL_FAST_SWEEP_GRID_MACROS_SVH
`define EIKONAL_FAST_SWEEP_GRID_MACROS_SVH

// same-cycle implication
`define EFSG_ASSERT_IMP(lbl, ck, rst, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rst)) (ante) |-> (cons)) \
    else $error("efsg check failed");

// next-cycle implication
`define EFSG_ASSERT_NXT(lbl, ck, rst, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rst)) (ante) |=> (cons)) \
    else $error("efsg check failed");

`endif

>>> design/efsg_pkg.sv
`default_nettype none
package efsg_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int PADDR_W      = 4;
  localparam int SQRT_STEPS   = 32;

  localparam logic [31:0] CELL_SIZE_RST = 32'd65536;
  localparam logic [6:0]  ROW_COUNT_RST = 7'd64;
  localparam logic [6:0]  COL_COUNT_RST = 7'd64;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_SOLVE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [1:0] REG_COL_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        pixel_index;
    logic signed [31:0] elevation;
    logic [15:0]        slope;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        pass_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_GATHER,
    ST_FI,
    ST_DIFF,
    ST_SQF,
    ST_SQD,
    ST_RAD,
    ST_ROOT,
    ST_UPD,
    ST_PEND
  } state_t;

endpackage
`default_nettype wire

>>> design/eikonal_fast_sweep_grid.sv
`default_nettype none
// load and read words: one per cycle, read result in the cycle after acceptance
// solve: copies n pixels, then per interior pixel and sweep gathers centre and neighbours
//   and relaxes (bit-serial root in the two-neighbour branch); an end state closes a pass
// four sweeps a pass, passes until one changes nothing, result word as busy falls
// reset (rst_n low, synchronous) clears control and config registers; memories are not cleared
// results cannot be stalled by the receiver
module eikonal_fast_sweep_grid #(
  parameter int MAX_ROWS = efsg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = efsg_pkg::MAX_COLS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire efsg_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  output efsg_pkg::out_item_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [efsg_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);

  // config registers
  logic [31:0] cell_size_r;
  logic [6:0]  row_count_r;
  logic [6:0]  col_count_r;
  logic        cfg_wr;

  // sequencer state
  efsg_pkg::state_t state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [1:0]    s_r, s_nxt;
  logic [CW-1:0] a_r, a_nxt;
  logic [RW-1:0] b_r, b_nxt;
  logic [15:0]   passes_r, passes_nxt;
  logic          changed_r, changed_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_oob_r, rd_oob_nxt;
  logic          sol_done_r, sol_done_nxt;
  logic [15:0]   sol_pass_r, sol_pass_nxt;

  // per-pixel datapath registers
  logic signed [31:0] cen_r, cen_nxt;
  logic signed [31:0] n1_r, n1_nxt, n2_r, n2_nxt, n3_r, n3_nxt, n4_r, n4_nxt;
  logic [15:0]        slope_r, slope_nxt;
  logic [47:0]        prod_r, prod_nxt;
  logic signed [31:0] u1_r, u1_nxt, u2_r, u2_nxt;
  logic [31:0]        fi_r, fi_nxt;
  logic [32:0]        d_r, d_nxt;
  logic               use_root_r, use_root_nxt;
  logic [63:0]        sq_r, sq_nxt;
  logic [63:0]        d2_r, d2_nxt;

  // memory ports
  logic          em_we, em_re;
  logic [AW-1:0] em_waddr, em_raddr;
  logic [47:0]   em_wdata, em_rdata;
  logic          sm_we, sm_re;
  logic [AW-1:0] sm_waddr, sm_raddr;
  logic [31:0]   sm_wdata, sm_rdata;

  // root unit
  logic        sq_start;
  logic [63:0] sq_rad;
  logic        sq_done;
  logic [31:0] sq_root;

  // grid geometry
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [NW-1:0] n_pix;
  logic          interior;
  logic          idown, jdown;
  logic [RW-1:0] i_cur;
  logic [CW-1:0] j_cur;
  logic [AW-1:0] p_cur;
  logic [AW-1:0] nb_addr;
  logic          b_last, a_last;

  // arithmetic helpers
  logic               acc;
  logic               idx_ok;
  logic [47:0]        prod_sh;
  logic signed [32:0] df;
  logic signed [32:0] usum;
  logic signed [32:0] uhalf;
  logic signed [31:0] umin;
  logic signed [33:0] prop;
  logic [15:0]        passes_inc;

  efsg_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_elev_ram (
    .clk   (clk),
    .we    (em_we),
    .waddr (em_waddr),
    .wdata (em_wdata),
    .re    (em_re),
    .raddr (em_raddr),
    .rdata (em_rdata)
  );

  efsg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_surf_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  efsg_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // apb register file, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= efsg_pkg::CELL_SIZE_RST;
      row_count_r <= efsg_pkg::ROW_COUNT_RST;
      col_count_r <= efsg_pkg::COL_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        efsg_pkg::REG_CELL_SIZE: cell_size_r <= pwdata;
        efsg_pkg::REG_ROW_COUNT: row_count_r <= pwdata[6:0];
        efsg_pkg::REG_COL_COUNT: col_count_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      efsg_pkg::REG_CELL_SIZE: prdata = cell_size_r;
      efsg_pkg::REG_ROW_COUNT: prdata = {25'd0, row_count_r};
      efsg_pkg::REG_COL_COUNT: prdata = {25'd0, col_count_r};
      default:                 prdata = '0;
    endcase
  end

  // geometry: grid clipped to the store, sweep order from the sweep number
  always_comb begin
    rows = RW'((32'(row_count_r) < 32'(MAX_ROWS)) ? 32'(row_count_r) : 32'(MAX_ROWS));
    cols = CW'((32'(col_count_r) < 32'(MAX_COLS)) ? 32'(col_count_r) : 32'(MAX_COLS));
    n_pix    = NW'(32'(rows) * 32'(cols));
    interior = (32'(rows) >= 32'd3) && (32'(cols) >= 32'd3);
    jdown    = s_r[0] ^ s_r[1];
    idown    = s_r[1];
    i_cur    = idown ? RW'(32'(rows) - 32'd2 - 32'(b_r)) : RW'(32'(b_r) + 32'd1);
    j_cur    = jdown ? CW'(32'(cols) - 32'd2 - 32'(a_r)) : CW'(32'(a_r) + 32'd1);
    p_cur    = AW'(32'(j_cur) * 32'(rows) + 32'(i_cur));
    b_last   = (32'(b_r) == 32'(rows) - 32'd3);
    a_last   = (32'(a_r) == 32'(cols) - 32'd3);
    case (k_r)
      3'd0:    nb_addr = p_cur;
      3'd1:    nb_addr = p_cur + AW'(1);
      3'd2:    nb_addr = p_cur - AW'(1);
      3'd3:    nb_addr = p_cur + AW'(rows);
      3'd4:    nb_addr = p_cur - AW'(rows);
      default: nb_addr = p_cur;
    endcase
  end

  // arithmetic of one relaxation
  always_comb begin
    prod_sh = prod_r >> 8;
    df      = 33'(u1_r) - 33'(u2_r);
    usum    = 33'(u1_r) + 33'(u2_r);
    uhalf   = usum >>> 1;
    umin    = (u1_r < u2_r) ? u1_r : u2_r;
    if (use_root_r) begin
      prop = 34'(uhalf) + $signed({2'b00, sq_root});
    end else begin
      prop = 34'(umin) + $signed({2'b00, fi_r});
    end
    passes_inc = (passes_r == 16'hFFFF) ? passes_r : passes_r + 16'd1;
  end

  assign busy   = (state_r != efsg_pkg::ST_IDLE);
  assign acc    = start && !busy;
  assign idx_ok = (32'(in_data.pixel_index) < 32'(DEPTH));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    s_nxt        = s_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    passes_nxt   = passes_r;
    changed_nxt  = changed_r;
    rd_pend_nxt  = 1'b0;
    rd_oob_nxt   = rd_oob_r;
    sol_done_nxt = 1'b0;
    sol_pass_nxt = sol_pass_r;
    cen_nxt      = cen_r;
    n1_nxt       = n1_r;
    n2_nxt       = n2_r;
    n3_nxt       = n3_r;
    n4_nxt       = n4_r;
    slope_nxt    = slope_r;
    prod_nxt     = prod_r;
    u1_nxt       = u1_r;
    u2_nxt       = u2_r;
    fi_nxt       = fi_r;
    d_nxt        = d_r;
    use_root_nxt = use_root_r;
    sq_nxt       = sq_r;
    d2_nxt       = d2_r;
    em_we        = 1'b0;
    em_waddr     = AW'(32'(in_data.pixel_index));
    em_wdata     = {in_data.elevation, in_data.slope};
    em_re        = 1'b0;
    em_raddr     = p_cur;
    sm_we        = 1'b0;
    sm_waddr     = p_cur;
    sm_wdata     = prop[31:0];
    sm_re        = 1'b0;
    sm_raddr     = nb_addr;
    sq_start     = 1'b0;
    sq_rad       = (sq_r - (d2_r >> 1) - {63'd0, d2_r[0]}) >> 1;

    case (state_r)
      efsg_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_data.func)
            efsg_pkg::FUNC_LOAD: begin
              em_we = idx_ok;
            end
            efsg_pkg::FUNC_READ: begin
              sm_re       = 1'b1;
              sm_raddr    = AW'(32'(in_data.pixel_index));
              rd_pend_nxt = 1'b1;
              rd_oob_nxt  = !idx_ok;
            end
            efsg_pkg::FUNC_SOLVE: begin
              cnt_nxt   = '0;
              state_nxt = efsg_pkg::ST_COPY;
            end
            default: ;
          endcase
        end
      end

      // elevation into surface, read one word ahead of the write
      efsg_pkg::ST_COPY: begin
        if (cnt_r < n_pix) begin
          em_re    = 1'b1;
          em_raddr = cnt_r[AW-1:0];
        end
        if (cnt_r != '0) begin
          sm_we    = 1'b1;
          sm_waddr = AW'(cnt_r - NW'(1));
          sm_wdata = em_rdata[47:16];
        end
        if (cnt_r == n_pix) begin
          passes_nxt  = '0;
          changed_nxt = 1'b0;
          s_nxt       = '0;
          a_nxt       = '0;
          b_nxt       = '0;
          k_nxt       = '0;
          if (n_pix == '0) begin
            sol_done_nxt = 1'b1;
            sol_pass_nxt = '0;
            state_nxt    = efsg_pkg::ST_IDLE;
          end else if (interior) begin
            state_nxt = efsg_pkg::ST_GATHER;
          end else begin
            state_nxt = efsg_pkg::ST_PEND;
          end
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end

      // centre and four neighbours through the one read port
      efsg_pkg::ST_GATHER: begin
        if (k_r < 3'd5) begin
          sm_re = 1'b1;
        end
        if (k_r == 3'd0) begin
          em_re = 1'b1;
        end
        case (k_r)
          3'd1: begin
            cen_nxt   = sm_rdata;
            slope_nxt = em_rdata[15:0];
          end
          3'd2:    n1_nxt = sm_rdata;
          3'd3:    n2_nxt = sm_rdata;
          3'd4:    n3_nxt = sm_rdata;
          3'd5:    n4_nxt = sm_rdata;
          default: ;
        endcase
        if (k_r == 3'd5) begin
          k_nxt     = '0;
          state_nxt = efsg_pkg::ST_FI;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end

      efsg_pkg::ST_FI: begin
        prod_nxt  = 48'(cell_size_r) * 48'(slope_r);
        u1_nxt    = (n1_r < n2_r) ? n1_r : n2_r;
        u2_nxt    = (n3_r < n4_r) ? n3_r : n4_r;
        state_nxt = efsg_pkg::ST_DIFF;
      end

      efsg_pkg::ST_DIFF: begin
        fi_nxt    = (|prod_sh[47:32]) ? 32'hFFFF_FFFF : prod_sh[31:0];
        d_nxt     = df[32] ? $unsigned(-df) : $unsigned(df);
        state_nxt = efsg_pkg::ST_SQF;
      end

      efsg_pkg::ST_SQF: begin
        use_root_nxt = (d_r < {1'b0, fi_r});
        sq_nxt       = 64'(fi_r) * 64'(fi_r);
        state_nxt    = (d_r < {1'b0, fi_r}) ? efsg_pkg::ST_SQD : efsg_pkg::ST_UPD;
      end

      efsg_pkg::ST_SQD: begin
        d2_nxt    = 64'(d_r[31:0]) * 64'(d_r[31:0]);
        state_nxt = efsg_pkg::ST_RAD;
      end

      efsg_pkg::ST_RAD: begin
        sq_start  = 1'b1;
        state_nxt = efsg_pkg::ST_ROOT;
      end

      efsg_pkg::ST_ROOT: begin
        if (sq_done) begin
          state_nxt = efsg_pkg::ST_UPD;
        end
      end

      // keep the proposal only if lower, then step along the sweep
      efsg_pkg::ST_UPD: begin
        if (prop < 34'(cen_r)) begin
          sm_we       = 1'b1;
          changed_nxt = 1'b1;
        end
        state_nxt = efsg_pkg::ST_GATHER;
        if (b_last) begin
          b_nxt = '0;
          if (a_last) begin
            a_nxt = '0;
            if (s_r == 2'd3) begin
              state_nxt = efsg_pkg::ST_PEND;
            end else begin
              s_nxt = s_r + 2'd1;
            end
          end else begin
            a_nxt = a_r + CW'(1);
          end
        end else begin
          b_nxt = b_r + RW'(1);
        end
      end

      // end of pass
      efsg_pkg::ST_PEND: begin
        passes_nxt = passes_inc;
        if (changed_r) begin
          changed_nxt = 1'b0;
          s_nxt       = '0;
          a_nxt       = '0;
          b_nxt       = '0;
          state_nxt   = efsg_pkg::ST_GATHER;
        end else begin
          sol_done_nxt = 1'b1;
          sol_pass_nxt = passes_inc;
          state_nxt    = efsg_pkg::ST_IDLE;
        end
      end

      default: state_nxt = efsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= efsg_pkg::ST_IDLE;
      cnt_r      <= '0;
      k_r        <= '0;
      s_r        <= '0;
      a_r        <= '0;
      b_r        <= '0;
      passes_r   <= '0;
      changed_r  <= 1'b0;
      rd_pend_r  <= 1'b0;
      sol_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      k_r        <= k_nxt;
      s_r        <= s_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      passes_r   <= passes_nxt;
      changed_r  <= changed_nxt;
      rd_pend_r  <= rd_pend_nxt;
      sol_done_r <= sol_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_oob_r   <= rd_oob_nxt;
    sol_pass_r <= sol_pass_nxt;
    cen_r      <= cen_nxt;
    n1_r       <= n1_nxt;
    n2_r       <= n2_nxt;
    n3_r       <= n3_nxt;
    n4_r       <= n4_nxt;
    slope_r    <= slope_nxt;
    prod_r     <= prod_nxt;
    u1_r       <= u1_nxt;
    u2_r       <= u2_nxt;
    fi_r       <= fi_nxt;
    d_r        <= d_nxt;
    use_root_r <= use_root_nxt;
    sq_r       <= sq_nxt;
    d2_r       <= d2_nxt;
  end

  // result word: read data straight from the surface memory register, else the solve pass count
  assign out_valid = rd_pend_r || sol_done_r;
  always_comb begin
    if (rd_pend_r) begin
      out_data.value      = rd_oob_r ? 32'sd0 : $signed(sm_rdata);
      out_data.pass_count = '0;
    end else begin
      out_data.value      = 32'sd0;
      out_data.pass_count = sol_pass_r;
    end
  end

endmodule
`default_nettype wire

>>> design/efsg_ram.sv
`default_nettype none
module efsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/efsg_isqrt.sv
`default_nettype none
module efsg_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  localparam int CNT_W = $clog2(efsg_pkg::SQRT_STEPS);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      x_r, x_nxt;
  logic [33:0]      rem_r, rem_nxt;
  logic [31:0]      root_r, root_nxt;
  logic [33:0]      rem_sh;
  logic [33:0]      trial;

  // one result bit per step, restoring
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r[31:0], x_r[63:62]};
    trial    = {root_r, 2'b01};
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (run_r) begin
      x_nxt = {x_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(efsg_pkg::SQRT_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

>>> design/efsg_checker.sv
`default_nettype none
`include "eikonal_fast_sweep_grid_macros.svh"
module efsg_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire efsg_pkg::in_item_t           in_data,
  input wire logic                         out_valid,
  input wire efsg_pkg::out_item_t          out_data,
  input wire logic                         psel,
  input wire logic                         pready
);

  logic acc;
  assign acc = start && !busy;

  // a load gives no word
  `EFSG_ASSERT_NXT(a_load_silent, clk, rst_n, acc && in_data.func == efsg_pkg::FUNC_LOAD, !out_valid)
  // a read answers in the next cycle with no pass count
  `EFSG_ASSERT_NXT(a_read_next, clk, rst_n, acc && in_data.func == efsg_pkg::FUNC_READ, out_valid && out_data.pass_count == 16'd0)
  // a solve holds the block busy
  `EFSG_ASSERT_NXT(a_solve_busy, clk, rst_n, acc && in_data.func == efsg_pkg::FUNC_SOLVE, busy && !out_valid)
  // finishing a solve delivers its word
  `EFSG_ASSERT_IMP(a_solve_word, clk, rst_n, $fell(busy) && $past(rst_n), out_valid && out_data.value == 32'sd0)
  // apb never waits
  `EFSG_ASSERT_IMP(a_pready, clk, rst_n, psel, pready)

endmodule

bind eikonal_fast_sweep_grid efsg_checker u_efsg_checker (.*);
`default_nettype wire

>>> tb/sv/eikonal_fast_sweep_grid_test.sv
module eikonal_fast_sweep_grid_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = efsg_pkg::MAX_ROWS_DEF * efsg_pkg::MAX_COLS_DEF;
  localparam int SETTLE     = 40;
  localparam int N_PHASES   = 9;
  localparam int RAND_ITEMS = 396;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  efsg_pkg::in_item_t in_data = '0;
  logic out_valid;
  efsg_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [efsg_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  eikonal_fast_sweep_grid u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow of the block: registers and the three stores
  logic [31:0] cell_q;
  logic [6:0]  rows_q;
  logic [6:0]  cols_q;
  int          elev_mem [DEPTH];
  logic [15:0] slope_mem [DEPTH];
  int          surf_mem [DEPTH];
  bit          surf_known [DEPTH];
  int          surf_known_cnt;
  bit          pass_dirty;

  efsg_pkg::out_item_t expected_words [$];
  int          fail_cnt;
  int          words_sent;
  int          results_seen;
  int          solves_sent;
  int          idle_pct;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  function automatic longint unsigned isqrt64(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint lmin(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  // upwind two-neighbour update of one interior pixel
  function automatic void relax_pixel(input int i, input int j, input int rows);
    int p;
    longint u1, u2, d, prop, s;
    longint unsigned fi, f2, d2, hr, du;
    p  = j * rows + i;
    u1 = lmin(surf_mem[p+1], surf_mem[p-1]);
    u2 = lmin(surf_mem[p+rows], surf_mem[p-rows]);
    fi = ({32'd0, cell_q} * {48'd0, slope_mem[p]}) >> 8;
    if (fi > 64'hFFFF_FFFF) fi = 64'hFFFF_FFFF;
    d  = (u1 > u2) ? u1 - u2 : u2 - u1;
    du = $unsigned(d);
    if (du < fi) begin
      f2   = fi * fi;
      d2   = du * du;
      hr   = f2 - (d2 >> 1) - (d2 & 64'd1);
      s    = u1 + u2;
      prop = ((s >= 0) ? s / 2 : -((-s + 1) / 2)) + longint'(isqrt64(hr >> 1));
    end else begin
      prop = lmin(u1, u2) + longint'(fi);
    end
    if (prop < longint'(surf_mem[p])) begin
      surf_mem[p] = int'(prop);
      pass_dirty  = 1'b1;
    end
  endfunction

  function automatic int unsigned solve_grid();
    int rows, cols, n, s, a, b, i, j;
    int unsigned passes;
    bit jdown, idown;
    rows = (rows_q < efsg_pkg::MAX_ROWS_DEF) ? rows_q : efsg_pkg::MAX_ROWS_DEF;
    cols = (cols_q < efsg_pkg::MAX_COLS_DEF) ? cols_q : efsg_pkg::MAX_COLS_DEF;
    n = rows * cols;
    passes = 0;
    for (int k = 0; k < n; k++) begin
      surf_mem[k] = elev_mem[k];
      if (!surf_known[k]) surf_known_cnt++;
      surf_known[k] = 1'b1;
    end
    if (n == 0) return 0;
    do begin
      pass_dirty = 1'b0;
      if (rows >= 3 && cols >= 3) begin
        for (s = 0; s < 4; s++) begin
          jdown = (s == 1 || s == 2);
          idown = (s == 2 || s == 3);
          for (a = 0; a < cols - 2; a++) begin
            j = jdown ? cols - 2 - a : 1 + a;
            for (b = 0; b < rows - 2; b++) begin
              i = idown ? rows - 2 - b : 1 + b;
              relax_pixel(i, j, rows);
            end
          end
        end
      end
      if (passes < 65535) passes++;
    end while (pass_dirty);
    return passes;
  endfunction

  // one accepted word through the shadow; returns 1 when a result follows
  function automatic bit grid_step(input efsg_pkg::in_item_t w,
                                   output efsg_pkg::out_item_t r);
    r = '0;
    case (w.func)
      efsg_pkg::FUNC_LOAD: begin
        elev_mem[w.pixel_index]  = w.elevation;
        slope_mem[w.pixel_index] = w.slope;
        return 1'b0;
      end
      efsg_pkg::FUNC_SOLVE: begin
        r.pass_count = 16'(solve_grid());
        return 1'b1;
      end
      efsg_pkg::FUNC_READ: begin
        r.value = surf_mem[w.pixel_index];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // result monitor: a strobe is accepted at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        fail_cnt++;
      end else begin
        efsg_pkg::out_item_t e;
        e = expected_words.pop_front();
        if (out_data.value !== e.value)
          report_mismatch("value", out_data.value, e.value);
        if (out_data.pass_count !== e.pass_count)
          report_mismatch("pass_count", out_data.pass_count, e.pass_count);
      end
    end
  end

  // send one word; typed-in expectation overrides the shadow when given
  task automatic send_word(input efsg_pkg::in_item_t w, input bit typed = 1'b0,
                           input efsg_pkg::out_item_t typed_res = '0);
    efsg_pkg::out_item_t r;
    // sender idles cycle by cycle before offering the word
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    if (grid_step(w, r)) expected_words.push_back(typed ? typed_res : r);
    if (w.func == efsg_pkg::FUNC_SOLVE) solves_sent++;
    words_sent++;
  endtask

  // psel stays high between back-to-back accesses; apb_release ends a group
  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] d,
                            output logic [31:0] q);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= efsg_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    q = prdata;
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] q;
    apb_access(1'b0, idx, '0, q);
    if (q !== want) report_mismatch("register readback", q, want);
  endtask

  // quiesce: nothing owed, block idle, then let any tail of work run out
  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(input logic [31:0] cs, input logic [6:0] r, input logic [6:0] c);
    logic [31:0] q;
    drain();
    apb_access(1'b1, efsg_pkg::REG_CELL_SIZE, cs, q);
    apb_access(1'b1, efsg_pkg::REG_ROW_COUNT, {25'd0, r}, q);
    apb_access(1'b1, efsg_pkg::REG_COL_COUNT, {25'd0, c}, q);
    cell_q = cs;
    rows_q = r;
    cols_q = c;
    check_reg(efsg_pkg::REG_CELL_SIZE, cs);
    check_reg(efsg_pkg::REG_ROW_COUNT, {25'd0, r});
    check_reg(efsg_pkg::REG_COL_COUNT, {25'd0, c});
    apb_release();
  endtask

  function automatic logic [31:0] rand_elev();
    if ($urandom_range(0, 9) < 7) return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    return $urandom();
  endfunction

  function automatic logic [15:0] rand_slope();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 512));
      1: return 16'($urandom_range(0, 4096));
      2: return 16'(0);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int grid_pixels();
    return ((rows_q < efsg_pkg::MAX_ROWS_DEF) ? rows_q : efsg_pkg::MAX_ROWS_DEF) *
           ((cols_q < efsg_pkg::MAX_COLS_DEF) ? cols_q : efsg_pkg::MAX_COLS_DEF);
  endfunction

  function automatic efsg_pkg::in_item_t rand_word(input int n);
    efsg_pkg::in_item_t w;
    int sel;
    w = '0;
    sel = $urandom_range(0, 99);
    w.elevation = rand_elev();
    w.slope     = rand_slope();
    if (sel < 3 && n > 0) begin
      w.func = efsg_pkg::FUNC_SOLVE;
      w.elevation = $urandom();
      w.slope = 16'($urandom());
    end else if (sel < 35 && surf_known_cnt > 0) begin
      w.func = efsg_pkg::FUNC_READ;
      w.pixel_index = 12'($urandom_range(0, DEPTH - 1));
      while (!surf_known[w.pixel_index]) w.pixel_index = 12'($urandom_range(0, DEPTH - 1));
      w.elevation = $urandom();
      w.slope = 16'($urandom());
    end else if (sel < 37) begin
      // unused func code, must be swallowed
      w.func = 2'd3;
      w.pixel_index = 12'($urandom());
    end else if (sel < 44 || n == 0) begin
      w.func = efsg_pkg::FUNC_LOAD;
      w.pixel_index = 12'($urandom());
    end else begin
      w.func = efsg_pkg::FUNC_LOAD;
      w.pixel_index = 12'($urandom_range(0, n - 1));
    end
    return w;
  endfunction

  typedef struct {
    efsg_pkg::in_item_t  w;
    bit                  typed;
    efsg_pkg::out_item_t res;
  } stim_row_t;

  typedef struct {
    logic [31:0] cs;
    logic [6:0]  r;
    logic [6:0]  c;
  } grid_cfg_t;

  stim_row_t directed [$];
  grid_cfg_t phases [N_PHASES];

  initial begin
    efsg_pkg::in_item_t w;
    int n;
    fail_cnt = 0;
    words_sent = 0;
    results_seen = 0;
    solves_sent = 0;
    surf_known_cnt = 0;
    idle_pct = 16;
    cell_q = efsg_pkg::CELL_SIZE_RST;
    rows_q = efsg_pkg::ROW_COUNT_RST;
    cols_q = efsg_pkg::COL_COUNT_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values straight out of reset
    check_reg(efsg_pkg::REG_CELL_SIZE, efsg_pkg::CELL_SIZE_RST);
    check_reg(efsg_pkg::REG_ROW_COUNT, {25'd0, efsg_pkg::ROW_COUNT_RST});
    check_reg(efsg_pkg::REG_COL_COUNT, {25'd0, efsg_pkg::COL_COUNT_RST});
    apb_release();

    // directed: 3x3 grid at unit spacing, field extremes on the ring
    set_grid(32'd65536, 7'd3, 7'd3);
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd0, 32'sh7FFF_FFFF, 16'hFFFF}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd1, 32'sh8000_0000, 16'h0000}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd2, 32'sd0, 16'd256}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd3, 32'sd65536, 16'd256}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd4, 32'sh7FFF_FFFF, 16'd256}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd5, 32'sd131072, 16'd256}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd6, -32'sd65536, 16'd0}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd7, 32'sd32768, 16'd512}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd8, 32'sh8000_0000, 16'hFFFF}, 0, '0});
    // highest index lies outside the grid but still in the store
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'hFFF, 32'sh7FFF_FFFF, 16'hFFFF}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_SOLVE, 12'hFFF, 32'shFFFF_FFFF, 16'hFFFF}, 0, '0});
    // ring pixels keep their elevation
    directed.push_back('{'{efsg_pkg::FUNC_READ, 12'd0, 32'sd0, 16'd0}, 1,
                         '{32'sh7FFF_FFFF, 16'd0}});
    directed.push_back('{'{efsg_pkg::FUNC_READ, 12'd1, 32'sd0, 16'd0}, 1,
                         '{32'sh8000_0000, 16'd0}});
    directed.push_back('{'{efsg_pkg::FUNC_READ, 12'd8, 32'sd0, 16'd0}, 1,
                         '{32'sh8000_0000, 16'd0}});
    directed.push_back('{'{efsg_pkg::FUNC_READ, 12'd4, 32'shFFFF_FFFF, 16'hFFFF}, 0, '0});
    directed.push_back('{'{2'd3, 12'd4, 32'sd1, 16'd1}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_LOAD, 12'd4, 32'sd0, 16'hFFFF}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_SOLVE, 12'd0, 32'sd0, 16'd0}, 0, '0});
    directed.push_back('{'{efsg_pkg::FUNC_READ, 12'd4, 32'sd0, 16'd0}, 0, '0});
    foreach (directed[k]) send_word(directed[k].w, directed[k].typed, directed[k].res);

    // grid settings: spacing extremes, long thin grids, no interior, empty grid,
    // and row or column counts past the store limit
    phases[0] = '{32'd1, 7'd4, 7'd4};
    phases[1] = '{32'hFFFF_FFFF, 7'd3, 7'd5};
    phases[2] = '{32'd65536, 7'd64, 7'd3};
    phases[3] = '{32'd16384, 7'd3, 7'd64};
    phases[4] = '{32'd65536, 7'd2, 7'd7};
    phases[5] = '{32'd98304, 7'd5, 7'd0};
    phases[6] = '{32'd65536, 7'd127, 7'd3};
    phases[7] = '{32'd0, 7'd6, 7'd5};
    phases[8] = '{32'd0, 7'd5, 7'd6};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 7) phases[ph].cs = $urandom_range(1, 32'h0004_0000);
      if (ph == 8) phases[ph].cs = $urandom();
      idle_pct = (ph < 3) ? 16 : (ph < 6) ? 61 : 0;
      set_grid(phases[ph].cs, phases[ph].r, phases[ph].c);
      n = grid_pixels();
      // fill the grid in use before anything solves over it
      for (int k = 0; k < n; k++) begin
        w = '0;
        w.func = efsg_pkg::FUNC_LOAD;
        w.pixel_index = 12'(k);
        w.elevation = rand_elev();
        w.slope = rand_slope();
        send_word(w);
      end
      w = '0;
      w.func = efsg_pkg::FUNC_SOLVE;
      send_word(w);
      for (int k = 0; k < RAND_ITEMS / N_PHASES; k++) send_word(rand_word(n));
    end

    drain();
    $display("run covered %0d words, %0d solves and %0d result words over %0d grid settings",
             words_sent, solves_sent, results_seen, N_PHASES + 1);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #200ms;
    $display("timeout with %0d result words still owed", expected_words.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
